>>> hdl/pcpp_pkg.sv
// Shared types, constants and hash function of the PTE child prefetch predictor.
`timescale 1ns / 1ps
`default_nettype none
package pcpp_pkg;

    localparam int DEF_PRED_ENTRIES     = 256;
    localparam int DEF_PENDING_ENTRIES  = 64;
    localparam int DEF_LINE_OFFSET_BITS = 6;

    localparam logic [63:0] MIX_SMALL  = 64'd2654435761;
    localparam logic [63:0] MIX_LARGE  = 64'd11400714819323198485;
    localparam logic [1:0]  CONF_TOP   = 2'd3;
    localparam logic [13:0] PERCENT    = 14'd100;

    localparam int IN_DATA_W  = 208;
    localparam int OUT_DATA_W = 80;

    // Configuration register indexes
    localparam logic [7:0] CFG_CONF_THR   = 8'd0;
    localparam logic [7:0] CFG_TRAIN_HITS = 8'd1;
    localparam logic [7:0] CFG_PRED_HITS  = 8'd2;
    localparam logic [7:0] CFG_GATE_PCT   = 8'd3;

    localparam logic [1:0] RST_CONF_THR   = 2'd2;
    localparam logic       RST_TRAIN_HITS = 1'b1;
    localparam logic       RST_PRED_HITS  = 1'b0;
    localparam logic [6:0] RST_GATE_PCT   = 7'd50;

    // Outcome codes
    localparam logic [3:0] OUT_ISSUED   = 4'd0;
    localparam logic [3:0] OUT_LEVEL0   = 4'd1;
    localparam logic [3:0] OUT_GATED    = 4'd2;
    localparam logic [3:0] OUT_TRAINED  = 4'd3;
    localparam logic [3:0] OUT_IGNORED  = 4'd4;
    localparam logic [3:0] OUT_LEAF     = 4'd5;
    localparam logic [3:0] OUT_INVALID  = 4'd6;
    localparam logic [3:0] OUT_MISMATCH = 4'd7;
    localparam logic [3:0] OUT_LOWCONF  = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEND_RD,
        ST_PRED_RD,
        ST_TRAIN,
        ST_LOOK_RD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic pend_rd;
        logic pred_rd;
        logic train_wr;
        logic look_rd;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic walk_in;
        logic lookup;
        logic out_free;
    } status_t;

    // Only the low 16 bits of the hash can reach a table index.
    function automatic logic [15:0] mix_hash(input logic [15:0] a, input logic [15:0] b,
                                             input logic [15:0] c);
        logic [31:0] pb;
        logic [31:0] pc;
        pb = {16'd0, b} * {16'd0, MIX_SMALL[15:0]};
        pc = {16'd0, c} * {16'd0, MIX_LARGE[15:0]};
        return a ^ pb[15:0] ^ pc[15:0];
    endfunction

endpackage
`default_nettype wire

>>> hdl/pcpp_ctrl.sv
// Sequencing state machine of the PTE child prefetch predictor.
`timescale 1ns / 1ps
`default_nettype none
module pcpp_ctrl
    import pcpp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = status.walk_in ? ST_PEND_RD : ST_FINISH;
                end
            end
            ST_PEND_RD: state_next = ST_PRED_RD;
            ST_PRED_RD: state_next = ST_TRAIN;
            ST_TRAIN:   state_next = status.lookup ? ST_LOOK_RD : ST_FINISH;
            ST_LOOK_RD: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_PEND_RD: cmd.pend_rd  = 1'b1;
            ST_PRED_RD: cmd.pred_rd  = 1'b1;
            ST_TRAIN:   cmd.train_wr = 1'b1;
            ST_LOOK_RD: cmd.look_rd  = 1'b1;
            ST_FINISH:  cmd.finish   = status.out_free;
            default:    cmd          = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/pcpp_datapath.sv
// Tables, input and output registers and decision logic of the predictor.
`timescale 1ns / 1ps
`default_nettype none
module pcpp_datapath
    import pcpp_pkg::*;
#(
    parameter int PRED_ENTRIES     = DEF_PRED_ENTRIES,
    parameter int PENDING_ENTRIES  = DEF_PENDING_ENTRIES,
    parameter int LINE_OFFSET_BITS = DEF_LINE_OFFSET_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_valid,
    input  wire logic [7:0]            cfg_index,
    input  wire logic [7:0]            cfg_data,
    input  wire cmd_t                  cmd,
    output status_t                    status
);

    localparam int PRED_IW = (PRED_ENTRIES > 1) ? $clog2(PRED_ENTRIES) : 1;
    localparam int PEND_IW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int LINE_W  = 64 - LINE_OFFSET_BITS;

    typedef struct packed {
        logic [63:0]       ip;
        logic [51:0]       page;
        logic [63:0]       parent;
        logic [LINE_W-1:0] line;
        logic [1:0]        conf;
    } pred_row_t;

    typedef struct packed {
        logic [63:0] ip;
        logic [51:0] page;
        logic [63:0] addr;
        logic [7:0]  level;
    } pend_row_t;

    // Input beat fields
    logic [63:0] in_addr;
    logic [7:0]  in_level;
    logic [63:0] in_ip;
    logic [51:0] in_page;
    logic [6:0]  in_occ;
    logic [6:0]  in_cap;

    assign in_addr  = s_tdata[63:0];
    assign in_level = s_tdata[71:64];
    assign in_ip    = s_tdata[135:72];
    assign in_page  = s_tdata[187:136];
    assign in_occ   = s_tdata[194:188];
    assign in_cap   = s_tdata[201:195];

    // Configuration
    logic [1:0] conf_thr_reg;
    logic       train_hits_reg;
    logic       pred_hits_reg;
    logic [6:0] gate_pct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_thr_reg   <= RST_CONF_THR;
            train_hits_reg <= RST_TRAIN_HITS;
            pred_hits_reg  <= RST_PRED_HITS;
            gate_pct_reg   <= RST_GATE_PCT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CONF_THR:   conf_thr_reg   <= cfg_data[1:0];
                CFG_TRAIN_HITS: train_hits_reg <= cfg_data[0];
                CFG_PRED_HITS:  pred_hits_reg  <= cfg_data[0];
                CFG_GATE_PCT:   gate_pct_reg   <= cfg_data[6:0];
                default:        ;
            endcase
        end
    end

    // Admission decode
    logic [13:0] occ_pct;
    logic [13:0] cap_pct;
    logic        gated;
    logic        hit_nopred;
    logic        walk_req;
    logic        predict;
    logic [3:0]  base_outcome;

    assign occ_pct    = {7'd0, in_occ} * PERCENT;
    assign cap_pct    = {7'd0, in_cap} * {7'd0, gate_pct_reg};
    assign gated      = occ_pct >= cap_pct;
    assign hit_nopred = s_tuser && !pred_hits_reg;
    assign predict    = !hit_nopred && !gated;

    always_comb
    begin
        priority if (hit_nopred)
        begin
            walk_req = train_hits_reg;
        end
        else if (gated)
        begin
            walk_req = s_tuser && train_hits_reg;
        end
        else
        begin
            walk_req = 1'b1;
        end
    end

    always_comb
    begin
        priority if (hit_nopred && !train_hits_reg)
        begin
            base_outcome = OUT_IGNORED;
        end
        else if (!hit_nopred && gated)
        begin
            base_outcome = OUT_GATED;
        end
        else if (in_level == 8'd0)
        begin
            base_outcome = OUT_LEVEL0;
        end
        else if (!predict)
        begin
            base_outcome = OUT_TRAINED;
        end
        else if (in_level == 8'd1)
        begin
            base_outcome = OUT_LEAF;
        end
        else
        begin
            base_outcome = OUT_INVALID;
        end
    end

    logic [63:0] addr_reg;
    logic [7:0]  level_reg;
    logic [63:0] ip_reg;
    logic [51:0] page_reg;
    logic        lookup_reg;
    logic [3:0]  base_outcome_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookup_reg       <= 1'b0;
            base_outcome_reg <= OUT_IGNORED;
        end
        else if (cmd.accept)
        begin
            lookup_reg       <= predict && (in_level > 8'd1);
            base_outcome_reg <= base_outcome;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg  <= in_addr;
            level_reg <= in_level;
            ip_reg    <= in_ip;
            page_reg  <= in_page;
        end
    end

    // Table indexes
    logic [15:0]        pend_up_hash;
    logic [15:0]        pend_cur_hash;
    logic [15:0]        pred_train_hash;
    logic [15:0]        pred_look_hash;
    logic [PEND_IW-1:0] pend_up_idx;
    logic [PEND_IW-1:0] pend_cur_idx;
    logic [PRED_IW-1:0] pred_train_idx;
    logic [PRED_IW-1:0] pred_look_idx;
    logic [PRED_IW-1:0] pred_rd_idx;
    logic [PRED_IW-1:0] pi_reg;

    pend_row_t pend_rd_reg;
    logic      pend_vld_rd_reg;
    pred_row_t pred_rd_reg;
    logic      pred_vld_rd_reg;

    assign pend_up_hash    = mix_hash(ip_reg[15:0], page_reg[15:0], {8'd0, level_reg} + 16'd1);
    assign pend_cur_hash   = mix_hash(ip_reg[15:0], page_reg[15:0], {8'd0, level_reg});
    assign pred_train_hash = mix_hash(ip_reg[15:0], pend_rd_reg.addr[15:0], page_reg[15:0]);
    assign pred_look_hash  = mix_hash(ip_reg[15:0], addr_reg[15:0], page_reg[15:0]);

    assign pend_up_idx    = (PENDING_ENTRIES > 1) ? pend_up_hash[PEND_IW-1:0] : '0;
    assign pend_cur_idx   = (PENDING_ENTRIES > 1) ? pend_cur_hash[PEND_IW-1:0] : '0;
    assign pred_train_idx = (PRED_ENTRIES > 1) ? pred_train_hash[PRED_IW-1:0] : '0;
    assign pred_look_idx  = (PRED_ENTRIES > 1) ? pred_look_hash[PRED_IW-1:0] : '0;
    assign pred_rd_idx    = cmd.look_rd ? pred_look_idx : pred_train_idx;

    // Parent match, taken when the pending row read comes back
    logic        pend_hit;
    logic        pend_hit_reg;
    logic [63:0] parent_reg;

    assign pend_hit = pend_vld_rd_reg && (pend_rd_reg.ip == ip_reg) &&
                      (pend_rd_reg.page == page_reg) &&
                      ({1'b0, pend_rd_reg.level} == ({1'b0, level_reg} + 9'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_hit_reg <= 1'b0;
        end
        else if (cmd.pred_rd)
        begin
            pend_hit_reg <= pend_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pred_rd)
        begin
            parent_reg <= pend_rd_reg.addr;
            pi_reg     <= pred_train_idx;
        end
    end

    // Training row
    logic [LINE_W-1:0] line_cur;
    logic              train_match;
    pred_row_t         pred_wr_row;
    pend_row_t         pend_wr_row;

    assign line_cur    = addr_reg[63:LINE_OFFSET_BITS];
    assign train_match = pred_vld_rd_reg && (pred_rd_reg.ip == ip_reg) &&
                         (pred_rd_reg.page == page_reg) && (pred_rd_reg.parent == parent_reg);

    always_comb
    begin
        pred_wr_row.ip     = ip_reg;
        pred_wr_row.page   = page_reg;
        pred_wr_row.parent = parent_reg;
        pred_wr_row.line   = line_cur;
        pred_wr_row.conf   = 2'd0;
        if (train_match && (pred_rd_reg.line == line_cur))
        begin
            pred_wr_row.conf = (pred_rd_reg.conf == CONF_TOP) ? CONF_TOP
                                                              : pred_rd_reg.conf + 2'd1;
        end
    end

    assign pend_wr_row.ip    = ip_reg;
    assign pend_wr_row.page  = page_reg;
    assign pend_wr_row.addr  = addr_reg;
    assign pend_wr_row.level = level_reg;

    // Memories
    pred_row_t pred_mem [PRED_ENTRIES];
    pend_row_t pend_mem [PENDING_ENTRIES];
    logic      pred_valid_reg [PRED_ENTRIES];
    logic      pend_valid_reg [PENDING_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (cmd.train_wr && pend_hit_reg)
        begin
            pred_mem[pi_reg] <= pred_wr_row;
        end
        if (cmd.pred_rd || cmd.look_rd)
        begin
            pred_rd_reg <= pred_mem[pred_rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.train_wr)
        begin
            pend_mem[pend_cur_idx] <= pend_wr_row;
        end
        if (cmd.pend_rd)
        begin
            pend_rd_reg <= pend_mem[pend_up_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PRED_ENTRIES; i++)
            begin
                pred_valid_reg[i] <= 1'b0;
            end
            for (int j = 0; j < PENDING_ENTRIES; j++)
            begin
                pend_valid_reg[j] <= 1'b0;
            end
            pred_vld_rd_reg <= 1'b0;
            pend_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (cmd.train_wr && pend_hit_reg)
            begin
                pred_valid_reg[pi_reg] <= 1'b1;
            end
            if (cmd.train_wr)
            begin
                pend_valid_reg[pend_cur_idx] <= 1'b1;
            end
            if (cmd.pred_rd || cmd.look_rd)
            begin
                pred_vld_rd_reg <= pred_valid_reg[pred_rd_idx];
            end
            if (cmd.pend_rd)
            begin
                pend_vld_rd_reg <= pend_valid_reg[pend_up_idx];
            end
        end
    end

    // Final decision
    logic [3:0] final_outcome;

    always_comb
    begin
        priority if (!lookup_reg)
        begin
            final_outcome = base_outcome_reg;
        end
        else if (!pred_vld_rd_reg)
        begin
            final_outcome = OUT_INVALID;
        end
        else if ((pred_rd_reg.ip != ip_reg) || (pred_rd_reg.page != page_reg) ||
                 (pred_rd_reg.parent != addr_reg))
        begin
            final_outcome = OUT_MISMATCH;
        end
        else if (pred_rd_reg.conf < conf_thr_reg)
        begin
            final_outcome = OUT_LOWCONF;
        end
        else
        begin
            final_outcome = OUT_ISSUED;
        end
    end

    logic        out_valid_reg;
    logic        pf_valid_reg;
    logic [63:0] pf_addr_reg;
    logic [7:0]  pf_level_reg;
    logic [3:0]  outcome_reg;
    logic        issue;

    assign issue = final_outcome == OUT_ISSUED;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            pf_valid_reg <= issue;
            pf_addr_reg  <= issue ? (64'(pred_rd_reg.line) << LINE_OFFSET_BITS) : 64'd0;
            pf_level_reg <= issue ? (level_reg - 8'd1) : 8'd0;
            outcome_reg  <= final_outcome;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tuser         = pf_valid_reg;
    assign m_tdata         = {4'd0, outcome_reg, pf_level_reg, pf_addr_reg};

    assign status.walk_in  = walk_req && (in_level != 8'd0);
    assign status.lookup   = lookup_reg;
    assign status.out_free = !out_valid_reg || m_tready;

    a_issue_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pf_valid_reg) |-> (outcome_reg == OUT_ISSUED))
        else $error("prefetch flagged without issued outcome");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pf_valid_reg) |-> (pf_addr_reg == 64'd0 && pf_level_reg == 8'd0))
        else $error("dropped result carries address or level");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a beat not yet taken");

    a_pred_set: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.train_wr && pend_hit_reg) |=> pred_valid_reg[$past(pi_reg)])
        else $error("trained prediction row left invalid");

endmodule
`default_nettype wire

>>> hdl/pte_child_prefetch_predictor.sv
// Top level of the PTE child prefetch predictor: controller plus datapath.
// Sequence: skipped or ignored items go from accept straight to the result; others
// read the pending, then the prediction table, then write both; lookup items then
// read the prediction table again. Throughput: one item in flight; the next is
// taken the cycle after the result loads (which waits for a free output), set by
// the serial pending/prediction table read-modify-write sequence on the single-ported tables.
// Reset: valid bits clear and configuration resets at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module pte_child_prefetch_predictor
    import pcpp_pkg::*;
#(
    parameter int PRED_ENTRIES     = DEF_PRED_ENTRIES,
    parameter int PENDING_ENTRIES  = DEF_PENDING_ENTRIES,
    parameter int LINE_OFFSET_BITS = DEF_LINE_OFFSET_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // pte_address[63:0], walk_level[71:64], instr_pointer[135:72],
    // page_number[187:136], mshr_occupancy[194:188], mshr_capacity[201:195]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // is_hit[0]
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // prefetch_address[63:0], prefetch level[71:64], outcome[75:72]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // prefetch_valid[0]
    output logic                       m_tuser,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [7:0]            cfg_index,
    input  wire logic [7:0]            cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    pcpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcpp_datapath #(
        .PRED_ENTRIES     (PRED_ENTRIES),
        .PENDING_ENTRIES  (PENDING_ENTRIES),
        .LINE_OFFSET_BITS (LINE_OFFSET_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire

>>> sim/tb_pte_child_prefetch_predictor.sv
// Self-checking testbench for the PTE child prefetch predictor, with its own prediction.
`timescale 1ns / 1ps
`default_nettype none
module tb_pte_child_prefetch_predictor;
    import pcpp_pkg::*;

    localparam int PRED_N    = DEF_PRED_ENTRIES;
    localparam int PEND_N    = DEF_PENDING_ENTRIES;
    localparam int LINE_OFS  = DEF_LINE_OFFSET_BITS;
    localparam int LIMIT     = 600000;
    localparam int CTX_N     = 6;

    typedef struct {
        logic [63:0] addr;
        logic [7:0]  level;
        logic [63:0] ip;
        logic [51:0] page;
        logic        hit;
        logic [6:0]  occ;
        logic [6:0]  cap;
    } walk_t;

    typedef struct {
        logic        pf_valid;
        logic [63:0] pf_addr;
        logic [7:0]  child_lvl;
        logic [3:0]  outcome;
    } prefetch_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    pte_child_prefetch_predictor i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // predictor copy of configuration and tables
    logic [1:0] conf_thr;
    logic       train_hits;
    logic       pred_hits;
    logic [6:0] gate_pct;

    logic        pv_valid [PRED_N];
    logic [63:0] pv_ip    [PRED_N];
    logic [51:0] pv_page  [PRED_N];
    logic [63:0] pv_parent[PRED_N];
    logic [57:0] pv_line  [PRED_N];
    logic [1:0]  pv_conf  [PRED_N];
    logic        pn_valid [PEND_N];
    logic [63:0] pn_ip    [PEND_N];
    logic [51:0] pn_page  [PEND_N];
    logic [63:0] pn_addr  [PEND_N];
    logic [7:0]  pn_level [PEND_N];

    walk_t     walk_q[$];
    prefetch_t prefetch_q[$];
    int errors = 0, accepted = 0, results = 0, issued = 0, cycles = 0;
    int gap = 0, stall = 0;
    bit quiet = 0;

    logic [63:0] ctx_ip  [CTX_N];
    logic [51:0] ctx_page[CTX_N];
    logic [63:0] ctx_addr[CTX_N][8];

    function automatic logic [63:0] child_slot(logic [63:0] ip, logic [63:0] parent,
                                               logic [63:0] page);
        return (ip ^ (parent * MIX_SMALL) ^ (page * MIX_LARGE)) % PRED_N;
    endfunction

    function automatic logic [63:0] parent_slot(logic [63:0] ip, logic [63:0] page,
                                                logic [63:0] lvl);
        return (ip ^ (page * MIX_SMALL) ^ (lvl * MIX_LARGE)) % PEND_N;
    endfunction

    // train parent entry, record this access, and look up its child line
    function automatic logic [3:0] train_and_lookup(walk_t w, bit predict,
                                                    output logic [57:0] line_out);
        logic [63:0] lvl, ps, pi, parent;
        logic [57:0] line;
        lvl = {56'd0, w.level};
        line_out = '0;
        if (lvl == 0)
            return OUT_LEVEL0;
        line = w.addr[63:LINE_OFS];
        ps = parent_slot(w.ip, {12'd0, w.page}, lvl + 1);
        if (pn_valid[ps] && pn_ip[ps] == w.ip && pn_page[ps] == w.page &&
            {56'd0, pn_level[ps]} == lvl + 1)
        begin
            parent = pn_addr[ps];
            pi = child_slot(w.ip, parent, {12'd0, w.page});
            if (pv_valid[pi] && pv_ip[pi] == w.ip && pv_page[pi] == w.page &&
                pv_parent[pi] == parent)
            begin
                if (pv_line[pi] == line)
                begin
                    if (pv_conf[pi] < CONF_TOP)
                        pv_conf[pi]++;
                end
                else
                begin
                    pv_line[pi] = line;
                    pv_conf[pi] = 2'd0;
                end
            end
            else
            begin
                pv_valid[pi] = 1'b1;
                pv_ip[pi] = w.ip;
                pv_page[pi] = w.page;
                pv_parent[pi] = parent;
                pv_line[pi] = line;
                pv_conf[pi] = 2'd0;
            end
        end
        ps = parent_slot(w.ip, {12'd0, w.page}, lvl);
        pn_valid[ps] = 1'b1;
        pn_ip[ps] = w.ip;
        pn_page[ps] = w.page;
        pn_addr[ps] = w.addr;
        pn_level[ps] = w.level;
        if (!predict)
            return OUT_TRAINED;
        if (lvl <= 1)
            return OUT_LEAF;
        pi = child_slot(w.ip, w.addr, {12'd0, w.page});
        if (!pv_valid[pi])
            return OUT_INVALID;
        if (!(pv_ip[pi] == w.ip && pv_page[pi] == w.page && pv_parent[pi] == w.addr))
            return OUT_MISMATCH;
        if (pv_conf[pi] < conf_thr)
            return OUT_LOWCONF;
        line_out = pv_line[pi];
        return OUT_ISSUED;
    endfunction

    function automatic prefetch_t predict_prefetch(walk_t w);
        prefetch_t p;
        logic [57:0] line;
        logic [3:0] oc;
        logic gated;
        gated = ({7'd0, w.occ} * 14'd100) >= ({7'd0, w.cap} * {7'd0, gate_pct});
        if (w.hit && !pred_hits)
            oc = train_hits ? train_and_lookup(w, 0, line) : OUT_IGNORED;
        else if (gated)
        begin
            if (w.hit && train_hits)
                void'(train_and_lookup(w, 0, line));
            oc = OUT_GATED;
        end
        else
            oc = train_and_lookup(w, 1, line);
        p.pf_valid = (oc == OUT_ISSUED);
        p.pf_addr = p.pf_valid ? {line, 6'd0} : '0;
        p.child_lvl = p.pf_valid ? w.level - 8'd1 : '0;
        p.outcome = oc;
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // input driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                prefetch_q = {prefetch_q, predict_prefetch(walk_q[0])};
                void'(walk_q.pop_front());
                accepted++;
                gap = pick_gap();
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap > 0)
                begin
                    gap--;
                    s_tvalid <= 1'b0;
                end
                else if (walk_q.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'd0, walk_q[0].cap, walk_q[0].occ, walk_q[0].page,
                                walk_q[0].ip, walk_q[0].level, walk_q[0].addr};
                    s_tuser <= walk_q[0].hit;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        prefetch_t e;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results++;
                if (prefetch_q.size() == 0)
                begin
                    errors++;
                    $error("unexpected result beat");
                end
                else
                begin
                    e = prefetch_q.pop_front();
                    if (e.pf_valid) issued++;
                    if (m_tuser !== e.pf_valid)
                    begin
                        errors++;
                        $error("prefetch_valid exp %0h got %0h", e.pf_valid, m_tuser);
                    end
                    if (m_tdata[63:0] !== e.pf_addr)
                    begin
                        errors++;
                        $error("prefetch_address exp %0h got %0h", e.pf_addr, m_tdata[63:0]);
                    end
                    if (m_tdata[71:64] !== e.child_lvl)
                    begin
                        errors++;
                        $error("prefetch level exp %0h got %0h", e.child_lvl, m_tdata[71:64]);
                    end
                    if (m_tdata[75:72] !== e.outcome)
                    begin
                        errors++;
                        $error("outcome exp %0h got %0h", e.outcome, m_tdata[75:72]);
                    end
                end
            end
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_CONF_THR:   conf_thr = val[1:0];
            CFG_TRAIN_HITS: train_hits = val[0];
            CFG_PRED_HITS:  pred_hits = val[0];
            CFG_GATE_PCT:   gate_pct = val[6:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(logic [1:0] thr, logic th, logic ph, logic [6:0] gp);
        write_reg(CFG_CONF_THR, {6'd0, thr});
        write_reg(CFG_TRAIN_HITS, {7'd0, th});
        write_reg(CFG_PRED_HITS, {7'd0, ph});
        write_reg(CFG_GATE_PCT, {1'b0, gp});
    endtask

    task automatic push_walk(logic [63:0] addr, logic [7:0] lvl, logic [63:0] ip,
                             logic [51:0] page, logic hit, logic [6:0] occ, logic [6:0] cap);
        walk_t w;
        w.addr = addr; w.level = lvl; w.ip = ip; w.page = page;
        w.hit = hit; w.occ = occ; w.cap = cap;
        walk_q = {walk_q, w};
    endtask

    task automatic drain();
        do @(posedge clk); while (walk_q.size() > 0 || s_tvalid || prefetch_q.size() > 0);
        repeat (10) @(posedge clk);
    endtask

    // mostly repeated walks down the same contexts so confidence builds up
    task automatic random_walks(int n);
        int c, top, lv;
        logic [63:0] a;
        while (n > 0)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                c = $urandom_range(0, CTX_N - 1);
                top = $urandom_range(0, 19) == 0 ? 255 : $urandom_range(2, 5);
                for (lv = top; lv >= 1 && n > 0; lv = (lv == 255) ? 4 : lv - 1)
                begin
                    a = ctx_addr[c][lv % 8];
                    if ($urandom_range(0, 9) == 0)
                        a = {$urandom, $urandom};
                    push_walk(a, lv[7:0], ctx_ip[c], ctx_page[c],
                              $urandom_range(0, 9) < 3, 7'($urandom_range(0, 20)),
                              7'($urandom_range(32, 64)));
                    n--;
                end
            end
            else
            begin
                push_walk({$urandom, $urandom}, 8'($urandom), {$urandom, $urandom},
                          52'({$urandom, $urandom}), 1'($urandom),
                          7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                n--;
            end
        end
    endtask

    initial
    begin
        int i, j;
        conf_thr = RST_CONF_THR;
        train_hits = RST_TRAIN_HITS;
        pred_hits = RST_PRED_HITS;
        gate_pct = RST_GATE_PCT;
        for (i = 0; i < PRED_N; i++) pv_valid[i] = 1'b0;
        for (i = 0; i < PEND_N; i++) pn_valid[i] = 1'b0;
        for (i = 0; i < CTX_N; i++)
        begin
            ctx_ip[i] = {$urandom, $urandom};
            ctx_page[i] = 52'({$urandom, $urandom});
            for (j = 0; j < 8; j++) ctx_addr[i][j] = {$urandom, $urandom};
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes and a range of outcomes at reset settings
        push_walk('0, 8'd0, '0, '0, 1'b0, 7'd0, 7'd64);
        push_walk('1, 8'd1, '1, '1, 1'b0, 7'd0, 7'd64);
        push_walk('1, 8'd255, '1, '1, 1'b0, 7'd0, 7'd64);
        push_walk('1, 8'd254, '1, '1, 1'b0, 7'd0, 7'd64);
        push_walk(64'h40, 8'd2, 64'h1, 52'h1, 1'b0, 7'd64, 7'd1);
        push_walk(64'h40, 8'd2, 64'h1, 52'h1, 1'b0, 7'd0, 7'd0);
        push_walk(64'h80, 8'd3, 64'h1, 52'h1, 1'b1, 7'd64, 7'd64);
        push_walk(64'h0, 8'd0, 64'h1, 52'h1, 1'b1, 7'd0, 7'd64);
        for (i = 0; i < 4; i++)
        begin
            push_walk(64'h1000, 8'd3, 64'h7, 52'h9, 1'b0, 7'd1, 7'd64);
            push_walk(64'h2040, 8'd2, 64'h7, 52'h9, 1'b0, 7'd1, 7'd64);
            push_walk(64'h3080, 8'd1, 64'h7, 52'h9, 1'b0, 7'd1, 7'd64);
        end
        push_walk(64'h5000, 8'd3, 64'h7, 52'h9, 1'b0, 7'd1, 7'd64);
        drain();

        quiet = 1;
        random_walks(160);
        drain();

        quiet = 0;
        set_mode(2'd0, 1'b0, 1'b1, 7'd100);
        push_walk(64'h40, 8'd2, 64'h3, 52'h3, 1'b1, 7'd0, 7'd64);
        random_walks(160);
        drain();

        set_mode(2'd3, 1'b1, 1'b1, 7'd0);
        random_walks(100);
        drain();

        set_mode(2'd3, 1'b1, 1'b0, 7'd1);
        random_walks(160);
        drain();

        set_mode(2'd1, 1'b1, 1'b1, 7'd100);
        random_walks(180);
        drain();

        set_mode(2'd2, 1'b0, 1'b0, 7'd50);
        random_walks(60);
        drain();

        if (prefetch_q.size() > 0)
            errors++;
        $display("Run covered %0d walk accesses over six register settings.", accepted);
        $display("%0d result beats checked, %0d of them issued prefetches.", results, issued);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
hdl/pcpp_pkg.sv
hdl/pcpp_ctrl.sv
hdl/pcpp_datapath.sv
hdl/pte_child_prefetch_predictor.sv
sim/tb_pte_child_prefetch_predictor.sv
